>>> rtl/tcsb_pkg.sv
// Package for the text console scrollback engine: geometry constants,
// character codes, action codes and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package tcsb_pkg;

  localparam int unsigned SCREEN_COLS  = 80;
  localparam int unsigned SCREEN_ROWS  = 25;
  localparam int unsigned BUFFER_LINES = 64;

  localparam int unsigned BUF_CELLS  = BUFFER_LINES * SCREEN_COLS;
  localparam int unsigned VIEW_ROWS  = (SCREEN_ROWS < BUFFER_LINES) ? SCREEN_ROWS : BUFFER_LINES;
  localparam int unsigned VIEW_CELLS = VIEW_ROWS * SCREEN_COLS;
  localparam int unsigned COPY_CELLS = VIEW_CELLS - SCREEN_COLS;
  localparam int unsigned COPY_SRC   = BUF_CELLS + SCREEN_COLS - VIEW_CELLS;
  localparam int unsigned LOOP_LIMIT = BUFFER_LINES + 2;

  localparam int unsigned ADDR_W = $clog2(BUF_CELLS);
  localparam int unsigned POS_W  = $clog2(BUF_CELLS + VIEW_CELLS + 1);
  localparam int unsigned COL_W  = $clog2(SCREEN_COLS);
  localparam int unsigned CP_W   = $clog2(COPY_CELLS + 1);
  localparam int unsigned K_W    = $clog2(LOOP_LIMIT + 1);

  localparam int unsigned ACT_W  = 2;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned FLD_W  = 13;
  localparam int unsigned CELL_W = 2 * CH_W;

  localparam logic [CH_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CH_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CH_W-1:0] CH_BLANK     = 8'd32;
  localparam logic [CH_W-1:0] COLOR_RESET  = 8'd7;

  typedef enum logic [ACT_W-1:0] {
    ACT_PRINT = 2'd0,
    ACT_UP    = 2'd1,
    ACT_DOWN  = 2'd2,
    ACT_READ  = 2'd3
  } tcsb_action_e;

  typedef struct packed {
    logic clr_step;
    logic load_in;
    logic print;
    logic view_up;
    logic view_down;
    logic rd_issue;
    logic rd_capture;
    logic copy_init;
    logic copy_step;
    logic ovf_finish;
    logic loop_step;
    logic blank_step;
    logic out_load;
  } tcsb_cmd_t;

  typedef struct packed {
    logic         clr_last;
    tcsb_action_e action;
    logic         overflow;
    logic         in_view;
    logic         k_at_limit;
    logic         vu_changed;
    logic         copy_done;
    logic         blank_last;
    logic         out_free;
  } tcsb_sts_t;

endpackage

`default_nettype wire

>>> rtl/tcsb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tcsb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/tcsb_datapath.sv
// Datapath of the console engine: cursor, view and wrap registers, cell buffer,
// copy/blank/clear counters and the output register. Uses tcsb_pkg, tcsb_ram.
`default_nettype none

module tcsb_datapath import tcsb_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire tcsb_cmd_t        cmd_i,
  output tcsb_sts_t             sts_o,
  input  wire logic             cfg_we_i,
  input  wire logic [CH_W-1:0]  cfg_wdata_i,
  input  wire logic [ACT_W-1:0] action_i,
  input  wire logic [CH_W-1:0]  ch_i,
  input  wire logic [FLD_W-1:0] cell_addr_i,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  output logic      [FLD_W-1:0] cursor_pos_o,
  output logic      [FLD_W-1:0] view_start_o,
  output logic                  wrapped_o,
  output logic      [CH_W-1:0]  cell_char_o,
  output logic      [CH_W-1:0]  cell_color_o
);

  localparam logic [POS_W-1:0] P_COLS  = POS_W'(SCREEN_COLS);
  localparam logic [POS_W-1:0] P_BUF   = POS_W'(BUF_CELLS);
  localparam logic [POS_W-1:0] P_VIEW  = POS_W'(VIEW_CELLS);
  localparam logic [POS_W-1:0] P_LOWV  = POS_W'(BUF_CELLS - VIEW_CELLS);
  localparam logic [POS_W-1:0] P_COPY  = POS_W'(COPY_CELLS);

  logic [CH_W-1:0]   color_q;
  tcsb_action_e      act_q;
  logic [CH_W-1:0]   ch_q;
  logic [FLD_W-1:0]  addr_q;
  logic [POS_W-1:0]  cursor_q, cursor_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [POS_W-1:0]  view_q, view_d;
  logic              full_q;
  logic [ADDR_W-1:0] clr_q;
  logic [CP_W-1:0]   cp_idx_q;
  logic              cp_pend_q;
  logic [ADDR_W-1:0] cp_wa_q;
  logic [COL_W-1:0]  bl_cnt_q;
  logic [K_W-1:0]    k_q;
  logic [CH_W-1:0]   rd_char_q, rd_color_q;
  logic              out_valid_q;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_wa, ram_ra;
  logic [CELL_W-1:0] ram_wd, ram_rd;

  logic [POS_W-1:0]  newest, top_end, vu_next, vd_next, vd_dec, oldest, nxt_line;
  logic [POS_W-1:0]  bl_addr;

  tcsb_ram #(
    .WIDTH (CELL_W),
    .DEPTH (BUF_CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_wa),
    .wdata_i (ram_wd),
    .raddr_i (ram_ra),
    .rdata_o (ram_rd)
  );

  always_comb begin
    newest   = cursor_q - POS_W'(col_q);
    top_end  = view_q + P_VIEW;
    nxt_line = newest + P_COLS;
    bl_addr  = cursor_q + POS_W'(bl_cnt_q);

    vu_next = view_q;
    if (!full_q) begin
      if (newest >= top_end) begin
        vu_next = view_q + P_COLS;
      end
    end else if (top_end - P_COLS != newest) begin
      if (top_end == P_BUF) begin
        vu_next = '0;
      end else begin
        vu_next = view_q + P_COLS;
      end
    end

    vd_dec = (view_q >= P_COLS) ? view_q - P_COLS : '0;
    oldest = '0;
    if (full_q && nxt_line != P_BUF) begin
      oldest = nxt_line;
    end
    vd_next = view_q;
    if (!full_q) begin
      vd_next = vd_dec;
    end else if (view_q != oldest) begin
      if (cursor_q >= P_LOWV) begin
        vd_next = vd_dec;
      end else if (view_q == '0) begin
        vd_next = P_LOWV;
      end else begin
        vd_next = vd_dec;
      end
    end
  end

  always_comb begin
    ram_we = 1'b0;
    ram_wa = '0;
    ram_wd = '0;
    ram_ra = '0;
    if (cmd_i.copy_step) begin
      ram_ra = ADDR_W'(POS_W'(COPY_SRC) + POS_W'(cp_idx_q));
    end else if (cmd_i.rd_issue) begin
      ram_ra = ADDR_W'(addr_q);
    end
    if (cmd_i.clr_step) begin
      ram_we = 1'b1;
      ram_wa = clr_q;
    end else if (cmd_i.print) begin
      case (ch_q)
        CH_NEWLINE: begin
          ram_we = 1'b0;
        end
        CH_BACKSPACE: begin
          ram_we = (cursor_q != '0);
          ram_wa = ADDR_W'(cursor_q - POS_W'(1));
          ram_wd = {color_q, CH_BLANK};
        end
        default: begin
          ram_we = (cursor_q < P_BUF);
          ram_wa = ADDR_W'(cursor_q);
          ram_wd = {color_q, ch_q};
        end
      endcase
    end else if (cmd_i.copy_step) begin
      ram_we = cp_pend_q;
      ram_wa = cp_wa_q;
      ram_wd = ram_rd;
    end else if (cmd_i.blank_step) begin
      ram_we = (bl_addr < P_BUF);
      ram_wa = ADDR_W'(bl_addr);
      ram_wd = {color_q, CH_BLANK};
    end
  end

  always_comb begin
    cursor_d = cursor_q;
    col_d    = col_q;
    view_d   = view_q;
    if (cmd_i.print) begin
      case (ch_q)
        CH_NEWLINE: begin
          cursor_d = nxt_line;
          col_d    = '0;
        end
        CH_BACKSPACE: begin
          if (cursor_q != '0) begin
            cursor_d = cursor_q - POS_W'(1);
            col_d    = (col_q == '0) ? COL_W'(SCREEN_COLS - 1) : col_q - COL_W'(1);
          end
        end
        default: begin
          cursor_d = cursor_q + POS_W'(1);
          col_d    = (col_q == COL_W'(SCREEN_COLS - 1)) ? '0 : col_q + COL_W'(1);
        end
      endcase
    end else if (cmd_i.ovf_finish) begin
      cursor_d = P_COPY;
      col_d    = '0;
      view_d   = '0;
    end else if (cmd_i.view_up || cmd_i.loop_step) begin
      view_d = vu_next;
    end else if (cmd_i.view_down) begin
      view_d = vd_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q     <= COLOR_RESET;
      cursor_q    <= '0;
      col_q       <= '0;
      view_q      <= '0;
      full_q      <= 1'b0;
      clr_q       <= '0;
      cp_idx_q    <= '0;
      cp_pend_q   <= 1'b0;
      bl_cnt_q    <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        color_q <= cfg_wdata_i;
      end
      cursor_q <= cursor_d;
      col_q    <= col_d;
      view_q   <= view_d;
      if (cmd_i.ovf_finish) begin
        full_q <= 1'b1;
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
      if (cmd_i.copy_init) begin
        cp_idx_q  <= '0;
        cp_pend_q <= 1'b0;
      end else if (cmd_i.copy_step) begin
        cp_pend_q <= (cp_idx_q != CP_W'(COPY_CELLS));
        if (cp_idx_q != CP_W'(COPY_CELLS)) begin
          cp_idx_q <= cp_idx_q + CP_W'(1);
        end
      end
      if (cmd_i.ovf_finish || cmd_i.loop_step) begin
        bl_cnt_q <= '0;
      end else if (cmd_i.blank_step) begin
        bl_cnt_q <= bl_cnt_q + COL_W'(1);
      end
      if (cmd_i.load_in) begin
        k_q <= '0;
      end else if (cmd_i.loop_step) begin
        k_q <= k_q + K_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      act_q      <= tcsb_action_e'(action_i);
      ch_q       <= ch_i;
      addr_q     <= cell_addr_i;
      rd_char_q  <= '0;
      rd_color_q <= '0;
    end else if (cmd_i.rd_capture && (addr_q < FLD_W'(BUF_CELLS))) begin
      rd_char_q  <= ram_rd[CH_W-1:0];
      rd_color_q <= ram_rd[CELL_W-1:CH_W];
    end
    if (cmd_i.copy_step) begin
      cp_wa_q <= ADDR_W'(cp_idx_q);
    end
    if (cmd_i.out_load) begin
      cursor_pos_o <= FLD_W'(cursor_q);
      view_start_o <= FLD_W'(view_q);
      wrapped_o    <= full_q;
      cell_char_o  <= rd_char_q;
      cell_color_o <= rd_color_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o.clr_last   = (clr_q == ADDR_W'(BUF_CELLS - 1));
    sts_o.action     = act_q;
    sts_o.overflow   = (cursor_q >= P_BUF);
    sts_o.in_view    = (cursor_q < top_end) && (cursor_q >= view_q);
    sts_o.k_at_limit = (k_q == K_W'(LOOP_LIMIT));
    sts_o.vu_changed = (vu_next != view_q);
    sts_o.copy_done  = (cp_idx_q == CP_W'(COPY_CELLS)) && !cp_pend_q;
    sts_o.blank_last = (bl_cnt_q == COL_W'(SCREEN_COLS - 1));
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

`default_nettype wire

>>> rtl/tcsb_ctrl.sv
// Controller of the console engine: sequences clear pass, actions, overflow
// copy, line blanking and scroll loop. Uses tcsb_pkg.
`default_nettype none

module tcsb_ctrl import tcsb_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire tcsb_sts_t sts_i,
  output tcsb_cmd_t      cmd_o,
  input  wire logic      in_valid_i,
  output logic           in_ready_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_READ,
    S_CHECK,
    S_COPY,
    S_BLANK,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts_i.action)
          ACT_PRINT: begin
            cmd_o.print = 1'b1;
            state_d     = S_CHECK;
          end
          ACT_UP: begin
            cmd_o.view_up = 1'b1;
            state_d       = S_DONE;
          end
          ACT_DOWN: begin
            cmd_o.view_down = 1'b1;
            state_d         = S_DONE;
          end
          ACT_READ: begin
            cmd_o.rd_issue = 1'b1;
            state_d        = S_READ;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_READ: begin
        cmd_o.rd_capture = 1'b1;
        state_d          = S_DONE;
      end
      S_CHECK: begin
        if (sts_i.overflow) begin
          cmd_o.copy_init = 1'b1;
          state_d         = S_COPY;
        end else if (sts_i.in_view || sts_i.k_at_limit || !sts_i.vu_changed) begin
          state_d = S_DONE;
        end else begin
          cmd_o.loop_step = 1'b1;
          state_d         = S_BLANK;
        end
      end
      S_COPY: begin
        if (sts_i.copy_done) begin
          cmd_o.ovf_finish = 1'b1;
          state_d          = S_BLANK;
        end else begin
          cmd_o.copy_step = 1'b1;
        end
      end
      S_BLANK: begin
        cmd_o.blank_step = 1'b1;
        if (sts_i.blank_last) begin
          state_d = S_CHECK;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/text_console_scrollback_engine.sv
// Text console engine with scrollback: 64 lines of 80 cells, 25-line view.
// After reset the cell buffer is cleared one cell per cycle, and no word is
// accepted while it clears. A scroll up/down passes through the dispatch and done
// states, a cell read through dispatch, read and done, and a print through
// dispatch, check and done; the result is loaded in the done state once the output
// register is free. Each line the view scrolls while printing adds a check and the
// blanking of one line, and a buffer overflow adds the copy, the blanking of a line
// and a check. The cell buffer moves one cell per cycle in clear, copy and blanking.
// A result waits in the output register while the next word is taken.
`default_nettype none

module text_console_scrollback_engine import tcsb_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CH_W-1:0]  cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ACT_W-1:0] action_i,
  input  wire logic [CH_W-1:0]  ch_i,
  input  wire logic [FLD_W-1:0] cell_addr_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic      [FLD_W-1:0] cursor_pos_o,
  output logic      [FLD_W-1:0] view_start_o,
  output logic                  wrapped_o,
  output logic      [CH_W-1:0]  cell_char_o,
  output logic      [CH_W-1:0]  cell_color_o
);

  tcsb_cmd_t cmd;
  tcsb_sts_t sts;

  tcsb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o)
  );

  tcsb_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .action_i     (action_i),
    .ch_i         (ch_i),
    .cell_addr_i  (cell_addr_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .cursor_pos_o (cursor_pos_o),
    .view_start_o (view_start_o),
    .wrapped_o    (wrapped_o),
    .cell_char_o  (cell_char_o),
    .cell_color_o (cell_color_o)
  );

endmodule

`default_nettype wire

>>> rtl/tcsb_checker.sv
// Port-level checker for the console engine, bound to the top level.
// Uses tcsb_pkg.
`default_nettype none

module tcsb_checker import tcsb_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             cfg_we_i,
  input wire logic [CH_W-1:0]  cfg_wdata_i,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic [ACT_W-1:0] action_i,
  input wire logic [CH_W-1:0]  ch_i,
  input wire logic [FLD_W-1:0] cell_addr_i,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic [FLD_W-1:0] cursor_pos_o,
  input wire logic [FLD_W-1:0] view_start_o,
  input wire logic             wrapped_o,
  input wire logic [CH_W-1:0]  cell_char_o,
  input wire logic [CH_W-1:0]  cell_color_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cursor_pos_o)
      && $stable(view_start_o) && $stable(cell_char_o))
    else $error("result word changed while stalled");

  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word accepted before first finished");

  a_wrap_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wrapped_o |=> wrapped_o)
    else $error("wrapped flag dropped");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cursor_pos_o < FLD_W'(BUF_CELLS)) && (view_start_o < FLD_W'(BUF_CELLS)))
    else $error("cursor or view beyond buffer");

endmodule

bind text_console_scrollback_engine tcsb_checker u_tcsb_checker (.*);

`default_nettype wire

>>> tb/sv/tcsb_console_checker.sv
// Checker for the text console scrollback engine: mirrors the cell buffer, cursor,
// view start and wrapped flag, predicts one result per accepted word and compares.
// Depends on tcsb_pkg.
`timescale 1ns / 100ps

module tcsb_console_checker import tcsb_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CH_W-1:0]  cfg_wdata_i,
  input  wire logic             in_valid_i,
  input  wire logic             in_ready_i,
  input  wire logic [ACT_W-1:0] action_i,
  input  wire logic [CH_W-1:0]  ch_i,
  input  wire logic [FLD_W-1:0] cell_addr_i,
  input  wire logic             out_valid_i,
  input  wire logic             out_ready_i,
  input  wire logic [FLD_W-1:0] cursor_pos_i,
  input  wire logic [FLD_W-1:0] view_start_i,
  input  wire logic             wrapped_i,
  input  wire logic [CH_W-1:0]  cell_char_i,
  input  wire logic [CH_W-1:0]  cell_color_i,
  output int unsigned           err_count_o,
  output int unsigned           pending_o
);

  typedef struct packed {
    logic [FLD_W-1:0] cursor;
    logic [FLD_W-1:0] view;
    logic             wrapped;
    logic [CH_W-1:0]  glyph;
    logic [CH_W-1:0]  attr;
  } console_view_t;

  logic [CELL_W-1:0] cells [BUF_CELLS];
  int unsigned       cursor;
  int unsigned       view_top;
  bit                wrapped;
  logic [CH_W-1:0]   pen;
  int unsigned       errs;
  console_view_t     expected_q [$];
  console_view_t     want;
  console_view_t     seen;

  function automatic int unsigned line_base(int unsigned pos);
    return pos / SCREEN_COLS * SCREEN_COLS;
  endfunction

  task automatic reset_console();
    for (int unsigned i = 0; i < BUF_CELLS; i++) cells[i] = '0;
    cursor = 0;
    view_top = 0;
    wrapped = 1'b0;
    pen = COLOR_RESET;
  endtask

  task automatic put_glyph(int unsigned pos, logic [CH_W-1:0] c);
    if (pos < BUF_CELLS) cells[pos] = {pen, c};
  endtask

  task automatic blank_line(int unsigned pos);
    for (int unsigned i = 0; i < SCREEN_COLS; i++) put_glyph(pos + i, CH_BLANK);
  endtask

  task automatic scroll_up();
    int unsigned newest;
    newest = line_base(cursor);
    if (!wrapped) begin
      if (newest >= view_top + VIEW_CELLS) view_top = view_top + SCREEN_COLS;
    end else if (view_top + VIEW_CELLS - SCREEN_COLS != newest) begin
      if (view_top + VIEW_CELLS == BUF_CELLS) view_top = 0;
      else view_top = view_top + SCREEN_COLS;
    end
  endtask

  task automatic scroll_down();
    int unsigned newest;
    int unsigned oldest;
    int unsigned back;
    newest = line_base(cursor);
    oldest = wrapped ? (newest + SCREEN_COLS) % BUF_CELLS : 0;
    back = (view_top >= SCREEN_COLS) ? view_top - SCREEN_COLS : 0;
    if (!wrapped) begin
      if (view_top > 0) view_top = back;
    end else if (view_top != oldest) begin
      if (cursor >= BUF_CELLS - VIEW_CELLS) begin
        if (view_top != 0) view_top = back;
      end else if (view_top == 0) begin
        view_top = BUF_CELLS - VIEW_CELLS;
      end else begin
        view_top = back;
      end
    end
  endtask

  task automatic fold_buffer();
    int unsigned col;
    int unsigned src;
    col = cursor % SCREEN_COLS;
    src = (cursor / SCREEN_COLS + 1) * SCREEN_COLS - VIEW_CELLS;
    for (int unsigned i = 0; i < COPY_CELLS; i++)
      cells[i] = (src + i < BUF_CELLS) ? cells[src + i] : '0;
    view_top = 0;
    cursor = COPY_CELLS + col;
    if (cursor >= BUF_CELLS) cursor = COPY_CELLS;
    blank_line(cursor);
    wrapped = 1'b1;
  endtask

  task automatic print_glyph(logic [CH_W-1:0] c);
    int unsigned prev;
    if (c == CH_NEWLINE) begin
      cursor = (cursor / SCREEN_COLS + 1) * SCREEN_COLS;
    end else if (c == CH_BACKSPACE) begin
      if (cursor > 0) begin
        cursor--;
        put_glyph(cursor, CH_BLANK);
      end
    end else begin
      put_glyph(cursor, c);
      cursor++;
    end
    if (cursor >= BUF_CELLS) fold_buffer();
    // scroll until the cursor is on screen; stop when the view sticks or after LOOP_LIMIT steps
    for (int unsigned k = 0; k < LOOP_LIMIT; k++) begin
      if (cursor < view_top + VIEW_CELLS && cursor >= view_top) break;
      prev = view_top;
      scroll_up();
      if (view_top == prev) break;
      blank_line(cursor);
    end
  endtask

  task automatic apply_word(input tcsb_action_e act, input logic [CH_W-1:0] c,
                            input logic [FLD_W-1:0] addr, output console_view_t res);
    res = '0;
    case (act)
      ACT_PRINT: print_glyph(c);
      ACT_UP:    scroll_up();
      ACT_DOWN:  scroll_down();
      ACT_READ: begin
        if (addr < BUF_CELLS) begin
          res.glyph = cells[addr][CH_W-1:0];
          res.attr  = cells[addr][CELL_W-1:CH_W];
        end
      end
      default: ;
    endcase
    res.cursor  = cursor[FLD_W-1:0];
    res.view    = view_top[FLD_W-1:0];
    res.wrapped = wrapped;
  endtask

  task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      errs++;
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_console();
      expected_q.delete();
      errs = 0;
      err_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen = '{cursor_pos_i, view_start_i, wrapped_i, cell_char_i, cell_color_i};
        if (expected_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected word, expected none actual %h", $time, seen);
        end else begin
          want = expected_q.pop_front();
          check_field("cursor_pos", want.cursor, seen.cursor);
          check_field("view_start", want.view, seen.view);
          check_field("wrapped", want.wrapped, seen.wrapped);
          check_field("cell_char", want.glyph, seen.glyph);
          check_field("cell_color", want.attr, seen.attr);
        end
      end
      if (cfg_we_i) pen = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        apply_word(tcsb_action_e'(action_i), ch_i, cell_addr_i, want);
        expected_q.push_back(want);
      end
      err_count_o <= errs;
      pending_o <= expected_q.size();
    end
  end

endmodule

>>> tb/sv/text_console_scrollback_engine_test.sv
// Top of the text console scrollback engine testbench: clock, reset, stimulus,
// color register writes and the verdict. Depends on tcsb_pkg, the engine and
// tcsb_console_checker.
`timescale 1ns / 100ps

module text_console_scrollback_engine_test;
  import tcsb_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 30_000_000;
  localparam int unsigned CHUNK_WORDS  = 100;
  localparam int unsigned CHUNKS       = 4;
  localparam int unsigned DRAIN_CYCLES = 100;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CH_W-1:0]  cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic [ACT_W-1:0] action = '0;
  logic [CH_W-1:0]  ch = '0;
  logic [FLD_W-1:0] cell_addr = '0;
  logic             out_ready = 1'b0;
  logic             in_ready;
  logic             out_valid;
  logic [FLD_W-1:0] cursor_pos;
  logic [FLD_W-1:0] view_start;
  logic             wrapped;
  logic [CH_W-1:0]  cell_char;
  logic [CH_W-1:0]  cell_color;
  int unsigned      fail_count;
  int unsigned      words_waiting;

  int unsigned  send_idle_pct = 0;
  int unsigned  take_idle_pct = 0;
  int unsigned  cycles = 0;
  int unsigned  burst_left = 0;
  tcsb_action_e burst_act = ACT_UP;

  text_console_scrollback_engine DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .action_i     (action),
    .ch_i         (ch),
    .cell_addr_i  (cell_addr),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .cursor_pos_o (cursor_pos),
    .view_start_o (view_start),
    .wrapped_o    (wrapped),
    .cell_char_o  (cell_char),
    .cell_color_o (cell_color)
  );

  tcsb_console_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .action_i     (action),
    .ch_i         (ch),
    .cell_addr_i  (cell_addr),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .cursor_pos_i (cursor_pos),
    .view_start_i (view_start),
    .wrapped_i    (wrapped),
    .cell_char_i  (cell_char),
    .cell_color_i (cell_color),
    .err_count_o  (fail_count),
    .pending_o    (words_waiting)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= take_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("text_console_scrollback_engine_test: errors");
      $finish;
    end
  end

  task automatic send_word(tcsb_action_e act, logic [CH_W-1:0] c, logic [FLD_W-1:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    ch <= c;
    cell_addr <= addr;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_waiting != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_color(logic [CH_W-1:0] value);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_word(output tcsb_action_e act, output logic [CH_W-1:0] c,
                             output logic [FLD_W-1:0] addr);
    int unsigned roll;
    if (burst_left > 0) begin
      burst_left--;
      act = burst_act;
    end else begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        burst_left = $urandom_range(40, 10);
        burst_act = roll[0] ? ACT_UP : ACT_DOWN;
        act = burst_act;
      end else if (roll < 65) begin
        act = ACT_PRINT;
      end else if (roll < 76) begin
        act = ACT_UP;
      end else if (roll < 87) begin
        act = ACT_DOWN;
      end else begin
        act = ACT_READ;
      end
    end
    roll = $urandom_range(99);
    if (roll < 22) c = CH_NEWLINE;
    else if (roll < 30) c = CH_BACKSPACE;
    else c = CH_W'($urandom_range(255));
    roll = $urandom_range(99);
    if (roll < 80) addr = FLD_W'($urandom_range(BUF_CELLS - 1));
    else if (roll < 90) addr = FLD_W'($urandom_range(8191, BUF_CELLS));
    else addr = FLD_W'($urandom);
  endtask

  initial begin
    tcsb_action_e     act;
    logic [CH_W-1:0]  c;
    logic [FLD_W-1:0] addr;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_word(ACT_PRINT, CH_BACKSPACE, 13'h1FFF);
    send_word(ACT_READ, 8'hFF, 13'd0);
    send_word(ACT_UP, 8'hFF, 13'h1FFF);
    send_word(ACT_DOWN, 8'h00, 13'd0);
    send_word(ACT_PRINT, 8'h00, 13'h1FFF);
    send_word(ACT_PRINT, 8'hFF, 13'd0);
    send_word(ACT_PRINT, 8'h55, 13'h0AAA);
    send_word(ACT_PRINT, CH_BACKSPACE, 13'd0);
    send_word(ACT_READ, 8'h00, 13'd0);
    send_word(ACT_READ, 8'h00, 13'd1);
    send_word(ACT_READ, 8'h00, 13'd2);
    send_word(ACT_READ, 8'h00, FLD_W'(BUF_CELLS - 1));
    send_word(ACT_READ, 8'h00, FLD_W'(BUF_CELLS));
    send_word(ACT_READ, 8'h00, 13'h1FFF);
    send_word(ACT_PRINT, CH_NEWLINE, 13'd0);
    send_word(ACT_PRINT, CH_BACKSPACE, 13'd0);
    send_word(ACT_PRINT, CH_NEWLINE, 13'd0);
    send_word(ACT_DOWN, 8'h00, 13'd0);
    send_word(ACT_UP, 8'h00, 13'd0);
    send_word(ACT_READ, 8'h00, 13'd79);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 14; take_idle_pct = 60; end
        1: begin send_idle_pct = 60; take_idle_pct = 14; end
        default: begin send_idle_pct = 0; take_idle_pct = 0; end
      endcase
      for (int chunk = 0; chunk < CHUNKS; chunk++) begin
        case (chunk)
          0: set_color(8'h00);
          1: set_color(8'hFF);
          default: set_color(CH_W'($urandom_range(255)));
        endcase
        repeat (CHUNK_WORDS) begin
          random_word(act, c, addr);
          send_word(act, c, addr);
        end
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("text_console_scrollback_engine_test: clean");
    end else begin
      $display("text_console_scrollback_engine_test: errors");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/tcsb_pkg.sv
rtl/tcsb_ram.sv
rtl/tcsb_datapath.sv
rtl/tcsb_ctrl.sv
rtl/text_console_scrollback_engine.sv
rtl/tcsb_checker.sv
tb/sv/tcsb_console_checker.sv
tb/sv/text_console_scrollback_engine_test.sv
